@@ design/assert_macros.svh @@
// Assertion shorthands for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rrli_pkg.sv @@
package rrli_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_PULL  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_REFUSED = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// per-word result info handed from the control to the result stage
	typedef struct packed {
		logic    valid;
		logic    more;
		status_t status;
	} info_t;

endpackage

@@ design/rrli_mem.sv @@
module rrli_mem import rrli_pkg::*; #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic              rd_en,
	input  logic [AW-1:0]     addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/rrli_ctrl.sv @@
module rrli_ctrl import rrli_pkg::*; #(
	parameter int NUM_LISTS = 8,
	parameter int MAX_LEN   = 64,
	parameter int AW        = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       cmd,
	input  logic [IDX_W-1:0] list_index,
	output logic             wr_en,
	output logic             rd_en,
	output logic [AW-1:0]    addr,
	output info_t            info
);

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int SW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int TW = $clog2(NUM_LISTS);

	logic [LW-1:0] len_q [NUM_LISTS];
	logic [LW-1:0] rp_q  [NUM_LISTS];
	logic [LW-1:0] len_d [NUM_LISTS];
	logic [LW-1:0] rp_d  [NUM_LISTS];
	logic [TW-1:0] turn_q, turn_d;
	logic          draining_q, draining_d;

	logic [NUM_LISTS-1:0] unread, unread_next, hit, grant;
	logic [TW-1:0]        sel;
	logic                 found;
	logic                 is_load, is_pull, is_clear;
	logic                 full, load_ok;
	logic [SW-1:0]        load_slot, pull_slot;

	assign is_load  = (cmd == CMD_LOAD);
	assign is_pull  = (cmd == CMD_PULL);
	assign is_clear = (cmd == CMD_CLEAR);

	always_comb begin
		for (int l = 0; l < NUM_LISTS; l++) begin
			unread[l] = (rp_q[l] < len_q[l]);
			hit[l]    = (int'(list_index) == l);
		end
	end

	// rotating priority encode, lowest offset from the turn pointer wins
	always_comb begin
		int cand;
		sel   = '0;
		found = 1'b0;
		for (int k = NUM_LISTS - 1; k >= 0; k--) begin
			cand = int'(turn_q) + k;
			if (cand >= NUM_LISTS) begin
				cand = cand - NUM_LISTS;
			end
			if (unread[cand]) begin
				sel   = TW'(cand);
				found = 1'b1;
			end
		end
		for (int l = 0; l < NUM_LISTS; l++) begin
			grant[l] = found && (sel == TW'(l));
		end
	end

	always_comb begin
		full      = 1'b0;
		load_slot = '0;
		pull_slot = '0;
		for (int l = 0; l < NUM_LISTS; l++) begin
			full      = full | (hit[l] && (len_q[l] >= LW'(MAX_LEN)));
			load_slot = load_slot | (hit[l] ? SW'(len_q[l]) : '0);
			pull_slot = pull_slot | (grant[l] ? SW'(rp_q[l]) : '0);
		end
	end

	assign load_ok = is_load && !draining_q && (int'(list_index) < NUM_LISTS) && !full;

	always_comb begin
		for (int l = 0; l < NUM_LISTS; l++) begin
			len_d[l] = len_q[l];
			rp_d[l]  = rp_q[l];
			if (is_clear) begin
				len_d[l] = '0;
				rp_d[l]  = '0;
			end else begin
				if (load_ok && hit[l]) begin
					len_d[l] = len_q[l] + LW'(1);
				end
				if (is_pull && grant[l]) begin
					rp_d[l] = rp_q[l] + LW'(1);
				end
			end
			unread_next[l] = (rp_d[l] < len_d[l]);
		end
	end

	always_comb begin
		turn_d     = turn_q;
		draining_d = draining_q;
		if (is_clear) begin
			turn_d     = '0;
			draining_d = 1'b0;
		end else if (is_pull) begin
			draining_d = 1'b1;
			if (found) begin
				turn_d = (sel == TW'(NUM_LISTS - 1)) ? '0 : sel + TW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LISTS; l++) begin
				len_q[l] <= '0;
				rp_q[l]  <= '0;
			end
			turn_q     <= '0;
			draining_q <= 1'b0;
		end else if (accept) begin
			for (int l = 0; l < NUM_LISTS; l++) begin
				len_q[l] <= len_d[l];
				rp_q[l]  <= rp_d[l];
			end
			turn_q     <= turn_d;
			draining_q <= draining_d;
		end
	end

	always_comb begin
		wr_en = accept && load_ok;
		rd_en = accept && is_pull && found;
		if (is_load) begin
			addr = AW'(list_index) * AW'(MAX_LEN) + AW'(load_slot);
		end else begin
			addr = AW'(sel) * AW'(MAX_LEN) + AW'(pull_slot);
		end
	end

	always_comb begin
		info.valid  = is_pull && found;
		info.more   = |unread_next;
		info.status = ST_OK;
		if (is_load && draining_q) begin
			info.status = ST_REFUSED;
		end else if (is_load && !load_ok) begin
			info.status = ST_FULL;
		end else if (is_pull && !found) begin
			info.status = ST_EMPTY;
		end
	end

endmodule

@@ design/round_robin_list_interleaver.sv @@
// Round-robin list interleaver. Commands: load (append load_value to list
// list_index), pull (next value round-robin over the lists that still hold
// unread values), clear, and no-op. One command is taken per clock whenever
// start is high; busy never rises. Each command yields exactly one result
// word in the next cycle, shown for a single cycle with done; the receiver
// must take it then. The result is registered, as is the read of the element
// store. Loads after the first pull are refused until a clear.
`include "assert_macros.svh"

module round_robin_list_interleaver import rrli_pkg::*; #(
	parameter int NUM_LISTS = 8,
	parameter int MAX_LEN   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [IDX_W-1:0]  list_index,
	input  logic [DATA_W-1:0] load_value,
	output logic              done,
	output logic [DATA_W-1:0] out_value,
	output logic              out_valid,
	output logic              more_left,
	output logic [1:0]        status
);

	localparam int DEPTH = NUM_LISTS * MAX_LEN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              accept;
	logic              wr_en, rd_en;
	logic [AW-1:0]     addr;
	logic [DATA_W-1:0] rd_data;
	info_t             info;
	info_t             info_s1;
	logic              done_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	rrli_ctrl #(
		.NUM_LISTS (NUM_LISTS),
		.MAX_LEN   (MAX_LEN),
		.AW        (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (cmd),
		.list_index (list_index),
		.wr_en      (wr_en),
		.rd_en      (rd_en),
		.addr       (addr),
		.info       (info)
	);

	rrli_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.rd_en   (rd_en),
		.addr    (addr),
		.wr_data (load_value),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			info_s1 <= '0;
		end else begin
			done_s1 <= accept;
			info_s1 <= accept ? info : '0;
		end
	end

	assign done      = done_s1;
	assign out_valid = info_s1.valid;
	assign out_value = info_s1.valid ? rd_data : '0;
	assign more_left = info_s1.more;
	assign status    = info_s1.status;

	`ASSERT_NEXT(a_one_result, clk, arst_n, accept, done, "accepted word gave no result")
	`ASSERT_IMPLIES(a_valid_in_word, clk, arst_n, out_valid, done, "out_valid outside a result")
	`ASSERT_IMPLIES(a_valid_ok, clk, arst_n, out_valid, status == ST_OK, "pulled word with status")
	`ASSERT_IMPLIES(a_empty_none_left, clk, arst_n, done && status == ST_EMPTY, !more_left,
		"empty pull while values remain")

endmodule

@@ tb/sv/round_robin_list_interleaver_tb.sv @@
`timescale 1ns / 100ps

import rrli_pkg::*;

class interleave_scoreboard;
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              valid;
		logic              more;
		status_t           status;
	} word_t;

	// local copy of the block state
	logic [DATA_W-1:0] elems [8][64];
	int unsigned       len   [8];
	int unsigned       rdpos [8];
	int unsigned       turn;
	bit                draining;

	word_t predicted_words [$];
	int unsigned errors;

	function void clear_lists();
		for (int l = 0; l < 8; l++) begin
			len[l]   = 0;
			rdpos[l] = 0;
		end
		turn     = 0;
		draining = 0;
	endfunction

	function bit any_unread();
		for (int l = 0; l < 8; l++)
			if (rdpos[l] < len[l])
				return 1;
		return 0;
	endfunction

	task report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		errors++;
	endtask

	// predict the word caused by one accepted command
	function void note_command(input cmd_t c, input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] v);
		word_t w;
		bit found;
		int unsigned l;
		w = '{value: '0, valid: 1'b0, more: 1'b0, status: ST_OK};
		found = 0;
		case (c)
			CMD_LOAD: begin
				if (draining)
					w.status = ST_REFUSED;
				else if (len[idx] >= 64)
					w.status = ST_FULL;
				else begin
					elems[idx][len[idx]] = v;
					len[idx]++;
				end
			end
			CMD_PULL: begin
				draining = 1;
				for (int k = 0; k < 8 && !found; k++) begin
					l = (turn + k) % 8;
					if (rdpos[l] < len[l]) begin
						w.value = elems[l][rdpos[l]];
						w.valid = 1'b1;
						rdpos[l]++;
						turn = (l + 1) % 8;
						found = 1;
					end
				end
				if (!found)
					w.status = ST_EMPTY;
			end
			CMD_CLEAR: clear_lists();
			default: ;
		endcase
		w.more = any_unread();
		predicted_words.push_back(w);
	endfunction

	task check_word(input logic [DATA_W-1:0] v, input logic vld, input logic more,
			input logic [1:0] st);
		word_t w;
		if (predicted_words.size() == 0) begin
			report_mismatch("result word with nothing expected");
			return;
		end
		w = predicted_words.pop_front();
		if (v !== w.value)
			report_mismatch($sformatf("out_value %h, expected %h", v, w.value));
		if (vld !== w.valid)
			report_mismatch($sformatf("out_valid %b, expected %b", vld, w.valid));
		if (more !== w.more)
			report_mismatch($sformatf("more_left %b, expected %b", more, w.more));
		if (st !== w.status)
			report_mismatch($sformatf("status %0d, expected %0d", st, w.status));
	endtask
endclass

module round_robin_list_interleaver_tb;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              start      = 1'b0;
	logic              busy;
	logic [1:0]        cmd        = CMD_NOP;
	logic [IDX_W-1:0]  list_index = '0;
	logic [DATA_W-1:0] load_value = '0;
	logic              done;
	logic [DATA_W-1:0] out_value;
	logic              out_valid;
	logic              more_left;
	logic [1:0]        status;

	interleave_scoreboard sb = new();
	int unsigned burst_left = 0;
	int unsigned sent       = 0;

	round_robin_list_interleaver dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.list_index (list_index),
		.load_value (load_value),
		.done       (done),
		.out_value  (out_value),
		.out_valid  (out_valid),
		.more_left  (more_left),
		.status     (status)
	);

	always #4 clk = ~clk;

	// result of the previous word is checked before the current word is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_word(out_value, out_valid, more_left, status);
			if (start && !busy)
				sb.note_command(cmd_t'(cmd), list_index, load_value);
		end
	end

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input cmd_t c, input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		start      <= 1'b1;
		cmd        <= c;
		list_index <= idx;
		load_value <= v;
		do @(posedge clk); while (busy);
		burst_left--;
		sent++;
	endtask

	// hold off until every outstanding word has come back
	task automatic wait_quiet();
		start <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.predicted_words.size() != 0);
	endtask

	// clear, load, drain, with overfilled lists, refused loads and no-ops mixed in
	task automatic run_round();
		int unsigned fill_cnt [8];
		int unsigned n;
		int unsigned total;
		int unsigned pulls;
		logic [IDX_W-1:0] idx;
		for (int l = 0; l < 8; l++)
			fill_cnt[l] = 0;
		send_word(CMD_CLEAR, IDX_W'($urandom), $urandom);
		if ($urandom_range(0, 5) == 0) begin
			idx = IDX_W'($urandom);
			repeat (66) begin
				send_word(CMD_LOAD, idx, rand_value());
				if (fill_cnt[idx] < 64)
					fill_cnt[idx]++;
			end
		end
		n = $urandom_range(0, 24);
		repeat (n) begin
			idx = IDX_W'($urandom);
			send_word(CMD_LOAD, idx, rand_value());
			if (fill_cnt[idx] < 64)
				fill_cnt[idx]++;
			if ($urandom_range(0, 9) == 0)
				send_word(CMD_NOP, IDX_W'($urandom), $urandom);
		end
		total = 0;
		for (int l = 0; l < 8; l++)
			total += fill_cnt[l];
		// now and then stop draining early
		if ($urandom_range(0, 7) == 0)
			pulls = $urandom_range(0, total);
		else
			pulls = total + $urandom_range(0, 3);
		repeat (pulls) begin
			send_word(CMD_PULL, IDX_W'($urandom), $urandom);
			if ($urandom_range(0, 15) == 0)
				send_word(CMD_LOAD, IDX_W'($urandom), rand_value());
			if ($urandom_range(0, 15) == 0)
				send_word(CMD_NOP, IDX_W'($urandom), $urandom);
		end
		if ($urandom_range(0, 3) == 0)
			wait_quiet();
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 10))
			send_word(cmd_t'($urandom_range(0, 3)), IDX_W'($urandom), rand_value());
	endtask

	initial begin
		int unsigned waited;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send_word(CMD_CLEAR, 3'd0, 32'h0);
		send_word(CMD_LOAD, 3'd0, 32'h7FFF_FFFF);
		send_word(CMD_LOAD, 3'd7, 32'h8000_0000);
		send_word(CMD_LOAD, 3'd3, 32'h0000_0000);
		send_word(CMD_LOAD, 3'd3, 32'hFFFF_FFFF);
		send_word(CMD_LOAD, 3'd5, 32'h0000_0001);
		send_word(CMD_NOP, 3'd7, 32'hFFFF_FFFF);
		repeat (5) send_word(CMD_PULL, 3'd0, 32'h0);
		send_word(CMD_PULL, 3'd7, 32'hFFFF_FFFF);   // nothing left
		send_word(CMD_LOAD, 3'd1, 32'h1234_5678);   // refused while draining
		send_word(CMD_NOP, 3'd0, 32'h0);
		send_word(CMD_CLEAR, 3'd7, 32'hFFFF_FFFF);
		send_word(CMD_PULL, 3'd0, 32'h0);           // empty pull still sets draining
		send_word(CMD_LOAD, 3'd2, 32'h5555_5555);
		send_word(CMD_CLEAR, 3'd0, 32'h0);
		send_word(CMD_LOAD, 3'd2, 32'h5555_5555);
		send_word(CMD_LOAD, 3'd2, 32'hAAAA_AAAA);
		send_word(CMD_LOAD, 3'd6, 32'hA5A5_5A5A);
		send_word(CMD_PULL, 3'd0, 32'h0);
		send_word(CMD_CLEAR, 3'd0, 32'h0);          // clear with unread left
		wait_quiet();

		// random part
		while (sent < 1450) begin
			if ($urandom_range(0, 4) == 0)
				run_noise();
			else
				run_round();
		end
		start <= 1'b0;

		waited = 0;
		while (sb.predicted_words.size() != 0 && waited < 200) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (sb.predicted_words.size() != 0)
			sb.report_mismatch($sformatf("%0d expected words never came",
				sb.predicted_words.size()));

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
